[rtl/bmt_pkg.sv]
package bmt_pkg;

  // Sample and window sizing.
  localparam int SAMPLE_BITS = 12;
  localparam int MAX_WINDOW  = 15;
  localparam int MIN_WINDOW  = 3;

  // Register and output field widths.
  localparam int WL_BITS     = 4;
  localparam int THR_BITS    = 12;
  localparam int CFG_BITS    = 12;
  localparam int CFG_IDX_BITS = 1;
  localparam int ANGLE_BITS  = 8;

  // Index into the sample store and sort row.
  localparam int IDX_BITS    = $clog2(MAX_WINDOW);
  // One odd-even transposition pass per entry sorts the whole row.
  localparam int PASS_BITS   = $clog2(MAX_WINDOW);
  localparam int SORT_PASSES = MAX_WINDOW;

  // Sort key: sample with a pad flag above it, so unused entries sort last.
  localparam int KEY_BITS    = SAMPLE_BITS + 1;

  localparam logic [ANGLE_BITS-1:0] ANGLE_HIGH = ANGLE_BITS'(180);
  localparam logic [ANGLE_BITS-1:0] ANGLE_LOW  = '0;

  // Register reset values.
  localparam logic [WL_BITS-1:0]  WINDOW_RESET    = WL_BITS'(5);
  localparam logic [THR_BITS-1:0] THRESHOLD_RESET = THR_BITS'(2048);

  // Register indexes.
  localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_LENGTH = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_LUX_LIMIT     = CFG_IDX_BITS'(1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SORT,
    ST_DONE
  } bmt_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic load;
    logic sort_step;
    logic sort_odd;
    logic out_load;
  } bmt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic window_full;
  } bmt_stat_t;

endpackage

[rtl/bmt_ctrl.sv]
module bmt_ctrl
  import bmt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  bmt_stat_t stat,
  output bmt_cmd_t  cmd
);

  bmt_state_t           state;
  bmt_state_t           state_next;
  logic [PASS_BITS-1:0] pass;
  logic [PASS_BITS-1:0] pass_next;
  logic                 out_free;
  logic                 accept;

  // The output register is free when empty or being drained this cycle.
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // Next state.
  always_comb begin
    state_next = state;
    pass_next  = pass;
    unique case (state)
      ST_IDLE: begin
        if (accept && stat.window_full) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_next = ST_SORT;
        pass_next  = '0;
      end
      ST_SORT: begin
        pass_next = pass + PASS_BITS'(1);
        if (pass == PASS_BITS'(SORT_PASSES - 1)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath commands.
  always_comb begin
    cmd = '0;
    unique case (state)
      ST_IDLE: cmd.accept = accept;
      ST_LOAD: cmd.load = 1'b1;
      ST_SORT: begin
        cmd.sort_step = 1'b1;
        cmd.sort_odd  = pass[0];
      end
      ST_DONE: cmd.out_load = out_free;
      default: cmd = '0;
    endcase
  end

  // State, pass counter and output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pass      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      pass  <= pass_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[rtl/bmt_datapath.sv]
module bmt_datapath
  import bmt_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]     cfg_data,
  input  logic [SAMPLE_BITS-1:0]  sample,
  input  bmt_cmd_t                cmd,
  output bmt_stat_t               stat,
  output logic [SAMPLE_BITS-1:0]  raw_middle,
  output logic [SAMPLE_BITS-1:0]  median,
  output logic [ANGLE_BITS-1:0]   servo_angle
);

  logic [WL_BITS-1:0]     window_length;
  logic [THR_BITS-1:0]    lux_limit;
  logic [WL_BITS-1:0]     w_eff;
  logic [IDX_BITS-1:0]    w_half;
  logic [IDX_BITS-1:0]    fill_count;
  logic [WL_BITS-1:0]     fill_inc;
  logic [SAMPLE_BITS-1:0] store [MAX_WINDOW];
  logic [KEY_BITS-1:0]    key [MAX_WINDOW];
  logic [KEY_BITS-1:0]    key_next [MAX_WINDOW];
  logic [SAMPLE_BITS-1:0] raw_hold;
  logic [SAMPLE_BITS-1:0] med_sel;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WINDOW_RESET;
      lux_limit     <= THRESHOLD_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_WINDOW_LENGTH: window_length <= cfg_data[WL_BITS-1:0];
        REG_LUX_LIMIT:     lux_limit     <= cfg_data[THR_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Effective window length, clamped to the supported range.
  always_comb begin
    if (window_length < WL_BITS'(MIN_WINDOW)) begin
      w_eff = WL_BITS'(MIN_WINDOW);
    end else if (window_length > WL_BITS'(MAX_WINDOW)) begin
      w_eff = WL_BITS'(MAX_WINDOW);
    end else begin
      w_eff = window_length;
    end
  end

  assign w_half   = IDX_BITS'(w_eff >> 1);
  assign fill_inc = WL_BITS'(fill_count) + WL_BITS'(1);
  assign stat.window_full = (fill_inc >= w_eff);

  // Fill counter; it restarts when a window completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (cmd.accept) begin
      fill_count <= stat.window_full ? '0 : IDX_BITS'(fill_inc);
    end
  end

  // Sample store, written in arrival order.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      store[fill_count] <= sample;
    end
  end

  // Sort row: load from the store, then odd-even transposition passes.
  always_comb begin
    for (int i = 0; i < MAX_WINDOW; i++) begin
      key_next[i] = key[i];
    end
    if (cmd.load) begin
      for (int i = 0; i < MAX_WINDOW; i++) begin
        key_next[i] = {(WL_BITS'(i) >= w_eff), store[i]};
      end
    end else if (cmd.sort_step) begin
      for (int i = 0; i < MAX_WINDOW - 1; i++) begin
        if ((((i % 2) == 1) == cmd.sort_odd) && (key[i] > key[i+1])) begin
          key_next[i]   = key[i+1];
          key_next[i+1] = key[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_WINDOW; i++) begin
      key[i] <= key_next[i];
    end
    if (cmd.load) begin
      raw_hold <= store[w_half];
    end
  end

  // Result register.
  assign med_sel = key[w_half][SAMPLE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      raw_middle  <= raw_hold;
      median      <= med_sel;
      servo_angle <= (THR_BITS'(med_sel) >= lux_limit) ? ANGLE_HIGH : ANGLE_LOW;
    end
  end

endmodule

[rtl/block_median_threshold_top.sv]
// Windowed median filter with a threshold decision.
// Input channel: sample with in_valid / in_stall. A request is taken at a
// rising edge where in_valid is high and in_stall is low.
// Output channel: raw_middle, median and servo_angle with out_valid /
// out_stall. A request is taken where out_valid is high and out_stall low.
// Configuration: cfg_write with cfg_index 0 sets window_length (clamped to
// 3..15), index 1 sets lux_limit. Write only while the block is idle.
// Input: a sample that does not complete a window leaves in_stall low, so
// the next sample can be taken at once. The sample that completes a window
// is followed by a load step and 15 odd-even transposition passes over a
// 15-entry compare-exchange row; in_stall stays high until the result enters the output register.
// The pass count is set by the row length, not the window length.
// When the receiver stalls, the result waits in the output register and
// new samples are still taken; only the next window's result then waits
// until the held result has been taken.
// Reset (rst, synchronous) restores the register defaults, empties the
// window and drops any pending result.
module block_median_threshold_top
  import bmt_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]     cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [SAMPLE_BITS-1:0]  sample,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [SAMPLE_BITS-1:0]  raw_middle,
  output logic [SAMPLE_BITS-1:0]  median,
  output logic [ANGLE_BITS-1:0]   servo_angle
);

  bmt_cmd_t  cmd;
  bmt_stat_t stat;

  // Sequencer.
  bmt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Store, sort row and result register.
  bmt_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .sample      (sample),
    .cmd         (cmd),
    .stat        (stat),
    .raw_middle  (raw_middle),
    .median      (median),
    .servo_angle (servo_angle)
  );

endmodule

[rtl/bmt_checker.sv]
module bmt_checker
  import bmt_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [SAMPLE_BITS-1:0] raw_middle,
  input logic [SAMPLE_BITS-1:0] median,
  input logic [ANGLE_BITS-1:0]  servo_angle
);

  // A held result keeps its value until it is taken.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(median) &&
      $stable(raw_middle) && $stable(servo_angle))
    else $error("held result changed");

  // The angle is one of the two servo positions.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (servo_angle == ANGLE_LOW || servo_angle == ANGLE_HIGH))
    else $error("bad servo angle");

  // Reset leaves the block ready with no pending result.
  assert property (@(posedge clk)
    rst |=> !in_stall && !out_valid)
    else $error("not idle after reset");

  // A result never appears on the cycle right after a sample request.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result too early");

endmodule

bind block_median_threshold_top bmt_checker u_bmt_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .raw_middle  (raw_middle),
  .median      (median),
  .servo_angle (servo_angle)
);
